FILE: rtl/core/cew_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cew_pkg;

	// defaults for the top-level parameters
	localparam int COORD_WIDTH_DEF = 18;
	localparam int FRAC_BITS_DEF   = 16;

	// result widths, fixed by the output format
	localparam int WEIGHT_W = 32;
	localparam int ROOT_W   = 32;

	// back-end control
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_ITER,
		BK_FIN
	} bk_state_t;

	// multiply sequence: products for dot and cross, then split squares
	typedef enum logic [4:0] {
		ST_DOT_X, ST_DOT_Y, ST_DOT_Z,
		ST_CX_P, ST_CX_N, ST_CY_P, ST_CY_N, ST_CZ_P, ST_CZ_N,
		ST_SX_LL, ST_SX_LH, ST_SX_HH,
		ST_SY_LL, ST_SY_LH, ST_SY_HH,
		ST_SZ_LL, ST_SZ_LH, ST_SZ_HH,
		ST_SD_LL, ST_SD_LH, ST_SD_HH,
		ST_DONE
	} step_t;

endpackage
`default_nettype wire

FILE: rtl/core/cew_front.sv
`timescale 1ns / 1ps
`default_nettype none
module cew_front #(
	parameter int CoordW = cew_pkg::COORD_WIDTH_DEF,
	parameter int TdW    = ((9 * cew_pkg::COORD_WIDTH_DEF + 7) / 8) * 8,
	parameter int EntW   = 6 * (cew_pkg::COORD_WIDTH_DEF + 1) + 1
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic [TdW-1:0]  s_tdata,
	input  wire logic            s_tlast,
	output logic                 push_valid,
	input  wire logic            push_ready,
	output logic [EntW-1:0]      push_data
);
	import cew_pkg::*;

	localparam int DifW = CoordW + 1;

	logic signed [CoordW-1:0] crd [9];
	logic signed [DifW-1:0]   ux, uy, uz, vx, vy, vz;
	logic                     v_s1;
	logic [EntW-1:0]          ent_s1;

	// unpack coordinates
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			crd[k] = s_tdata[k*CoordW +: CoordW];
		end
	end

	// edge vectors seen from the opposite vertex
	assign ux = DifW'(crd[0]) - DifW'(crd[6]);
	assign uy = DifW'(crd[1]) - DifW'(crd[7]);
	assign uz = DifW'(crd[2]) - DifW'(crd[8]);
	assign vx = DifW'(crd[3]) - DifW'(crd[6]);
	assign vy = DifW'(crd[4]) - DifW'(crd[7]);
	assign vz = DifW'(crd[5]) - DifW'(crd[8]);

	assign s_tready = !v_s1 || push_ready;

	// stage register toward the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ent_s1 <= {s_tlast, vz, vy, vx, uz, uy, ux};
		end
	end

	assign push_valid = v_s1;
	assign push_data  = ent_s1;

endmodule
`default_nettype wire

FILE: rtl/core/cew_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module cew_queue #(
	parameter int EntW = 6 * (cew_pkg::COORD_WIDTH_DEF + 1) + 1
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire logic [EntW-1:0] push_data,
	output logic                 pop_valid,
	input  wire logic            pop_ready,
	output logic [EntW-1:0]      pop_data
);
	import cew_pkg::*;

	logic [EntW-1:0] mem_q [2];
	logic            wr_ptr_q, rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            push, pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/cew_back.sv
`timescale 1ns / 1ps
`default_nettype none
module cew_back #(
	parameter int CoordW = cew_pkg::COORD_WIDTH_DEF,
	parameter int FracW  = cew_pkg::FRAC_BITS_DEF,
	parameter int EntW   = 6 * (cew_pkg::COORD_WIDTH_DEF + 1) + 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          pop_valid,
	output logic                               pop_ready,
	input  wire logic [EntW-1:0]               pop_data,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [cew_pkg::WEIGHT_W-1:0]       m_tdata,
	output logic                               m_tuser
);
	import cew_pkg::*;

	localparam int DifW  = CoordW + 1;
	localparam int ProdW = 2 * DifW;
	localparam int DotW  = ProdW + 2;
	localparam int CrW   = ProdW + 1;
	localparam int MagW  = DotW;
	localparam int HW    = (MagW + 1) / 2;
	localparam int MW    = (DifW > HW + 1) ? DifW : HW + 1;
	localparam int NsqW  = 2 * CrW + 2;
	localparam int TgtW  = 2 * (DotW + FracW - 1);
	localparam int AccW  = (NsqW + 66 > TgtW + 2) ? NsqW + 66 : TgtW + 2;
	localparam int ShT   = 2 * FracW - 2;
	localparam int CShft = 2 * (ROOT_W - 1);

	// saturation bounds of the running sum
	localparam logic signed [WEIGHT_W+1:0] SUM_MAX = $signed({3'b000, {(WEIGHT_W - 1){1'b1}}});
	localparam logic signed [WEIGHT_W+1:0] SUM_MIN = $signed({3'b111, {(WEIGHT_W - 1){1'b0}}});

	bk_state_t state_q, state_nx;

	logic signed [DifW-1:0]   ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;
	logic                     last_q;
	logic signed [DotW-1:0]   dot_q;
	logic signed [CrW-1:0]    cx_q, cy_q, cz_q;
	logic [NsqW-1:0]          nsq_q;
	logic [AccW-1:0]          r_q, a_q, c_q;
	logic [ROOT_W-1:0]        q_q;
	logic [4:0]               bit_q;
	step_t                    cnt_q, pstep_s1;
	logic                     pv_s1;
	logic signed [2*MW-1:0]   prod_s1;
	logic signed [WEIGHT_W-1:0] wsum_q;
	logic                     deg_q, degtri_q;
	logic                     out_valid_q, out_deg_q;
	logic [WEIGHT_W-1:0]      out_w_q;

	logic signed [MW-1:0]     opa, opb;
	logic [MagW-1:0]          mag_sel, mag_cx, mag_cy, mag_cz, mag_dot;
	logic [AccW-1:0]          pu;
	logic [AccW:0]            diff;
	logic                     take;
	logic [AccW-1:0]          a_add;
	logic [ROOT_W-1:0]        qc;
	logic signed [ROOT_W:0]   contrib;
	logic signed [WEIGHT_W+1:0] sum_w;
	logic signed [WEIGHT_W-1:0] wsum_nx;
	logic                     deg_nx;
	logic                     fin_go;

	// magnitudes for the split squares
	assign mag_cx  = MagW'(cx_q[CrW-1] ? -cx_q : cx_q);
	assign mag_cy  = MagW'(cy_q[CrW-1] ? -cy_q : cy_q);
	assign mag_cz  = MagW'(cz_q[CrW-1] ? -cz_q : cz_q);
	assign mag_dot = MagW'(dot_q[DotW-1] ? -dot_q : dot_q);

	// operand select for the shared multiplier
	always_comb begin
		mag_sel = mag_dot;
		opa     = MW'(ux_q);
		opb     = MW'(vx_q);
		case (cnt_q)
			ST_SX_LL, ST_SX_LH, ST_SX_HH: mag_sel = mag_cx;
			ST_SY_LL, ST_SY_LH, ST_SY_HH: mag_sel = mag_cy;
			ST_SZ_LL, ST_SZ_LH, ST_SZ_HH: mag_sel = mag_cz;
			default:                      mag_sel = mag_dot;
		endcase
		case (cnt_q)
			ST_DOT_X: begin opa = MW'(ux_q); opb = MW'(vx_q); end
			ST_DOT_Y: begin opa = MW'(uy_q); opb = MW'(vy_q); end
			ST_DOT_Z: begin opa = MW'(uz_q); opb = MW'(vz_q); end
			ST_CX_P:  begin opa = MW'(uy_q); opb = MW'(vz_q); end
			ST_CX_N:  begin opa = MW'(uz_q); opb = MW'(vy_q); end
			ST_CY_P:  begin opa = MW'(uz_q); opb = MW'(vx_q); end
			ST_CY_N:  begin opa = MW'(ux_q); opb = MW'(vz_q); end
			ST_CZ_P:  begin opa = MW'(ux_q); opb = MW'(vy_q); end
			ST_CZ_N:  begin opa = MW'(uy_q); opb = MW'(vx_q); end
			ST_SX_LL, ST_SY_LL, ST_SZ_LL, ST_SD_LL: begin
				opa = MW'(mag_sel[HW-1:0]);
				opb = MW'(mag_sel[HW-1:0]);
			end
			ST_SX_LH, ST_SY_LH, ST_SZ_LH, ST_SD_LH: begin
				opa = MW'(mag_sel[HW-1:0]);
				opb = MW'(mag_sel[MagW-1:HW]);
			end
			ST_SX_HH, ST_SY_HH, ST_SZ_HH, ST_SD_HH: begin
				opa = MW'(mag_sel[MagW-1:HW]);
				opb = MW'(mag_sel[MagW-1:HW]);
			end
			default: begin opa = MW'(ux_q); opb = MW'(vx_q); end
		endcase
	end

	// shifted partial square
	always_comb begin
		case (pstep_s1)
			ST_SX_LL, ST_SY_LL, ST_SZ_LL: pu = AccW'($unsigned(prod_s1));
			ST_SX_LH, ST_SY_LH, ST_SZ_LH: pu = AccW'($unsigned(prod_s1)) << (HW + 1);
			ST_SX_HH, ST_SY_HH, ST_SZ_HH: pu = AccW'($unsigned(prod_s1)) << (2 * HW);
			ST_SD_LL: pu = AccW'($unsigned(prod_s1)) << ShT;
			ST_SD_LH: pu = AccW'($unsigned(prod_s1)) << (HW + 1 + ShT);
			ST_SD_HH: pu = AccW'($unsigned(prod_s1)) << (2 * HW + ShT);
			default:  pu = '0;
		endcase
	end

	// one root bit: trial subtract of the next increment
	assign diff  = {1'b0, r_q} - {1'b0, a_q} - {1'b0, c_q};
	assign take  = !diff[AccW];
	assign a_add = take ? (a_q + (c_q << 1)) : a_q;

	// saturated accumulation of the half cotangent
	assign qc      = (q_q > (ROOT_W'(1) << (ROOT_W - 1))) ? (ROOT_W'(1) << (ROOT_W - 1)) : q_q;
	assign contrib = dot_q[DotW-1] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
	assign sum_w   = (WEIGHT_W + 2)'(wsum_q) + (WEIGHT_W + 2)'(contrib);
	always_comb begin
		if (degtri_q) begin
			wsum_nx = wsum_q;
		end else if (sum_w > SUM_MAX) begin
			wsum_nx = {1'b0, {(WEIGHT_W - 1){1'b1}}};
		end else if (sum_w < SUM_MIN) begin
			wsum_nx = {1'b1, {(WEIGHT_W - 1){1'b0}}};
		end else begin
			wsum_nx = WEIGHT_W'(sum_w);
		end
	end
	assign deg_nx = deg_q || degtri_q;

	// control outputs
	always_comb begin
		pop_ready = (state_q == BK_IDLE);
		fin_go    = (state_q == BK_FIN) && (!last_q || !out_valid_q || m_tready);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			BK_IDLE: if (pop_valid) state_nx = BK_MUL;
			BK_MUL: begin
				if (cnt_q == ST_DONE) state_nx = (nsq_q == '0) ? BK_FIN : BK_ITER;
			end
			BK_ITER: if (bit_q == 5'd0) state_nx = BK_FIN;
			BK_FIN:  if (fin_go) state_nx = BK_IDLE;
			default: state_nx = BK_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			pv_s1       <= 1'b0;
			wsum_q      <= '0;
			deg_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			pv_s1   <= (state_q == BK_MUL) && (cnt_q != ST_DONE);
			if (fin_go) begin
				wsum_q <= last_q ? '0 : wsum_nx;
				deg_q  <= last_q ? 1'b0 : deg_nx;
			end
			if (fin_go && last_q) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_s1  <= opa * opb;
		pstep_s1 <= cnt_q;
		if (pop_valid && pop_ready) begin
			{last_q, vz_q, vy_q, vx_q, uz_q, uy_q, ux_q} <= pop_data;
			cnt_q <= ST_DOT_X;
			dot_q <= '0;
			cx_q  <= '0;
			cy_q  <= '0;
			cz_q  <= '0;
			nsq_q <= '0;
			r_q   <= '0;
		end
		if (state_q == BK_MUL && cnt_q != ST_DONE) begin
			cnt_q <= step_t'(cnt_q + 5'd1);
		end
		if (pv_s1) begin
			case (pstep_s1)
				ST_DOT_X, ST_DOT_Y, ST_DOT_Z: dot_q <= dot_q + DotW'(prod_s1);
				ST_CX_P: cx_q <= cx_q + CrW'(prod_s1);
				ST_CX_N: cx_q <= cx_q - CrW'(prod_s1);
				ST_CY_P: cy_q <= cy_q + CrW'(prod_s1);
				ST_CY_N: cy_q <= cy_q - CrW'(prod_s1);
				ST_CZ_P: cz_q <= cz_q + CrW'(prod_s1);
				ST_CZ_N: cz_q <= cz_q - CrW'(prod_s1);
				ST_SD_LL, ST_SD_LH, ST_SD_HH: r_q <= r_q + pu;
				default: nsq_q <= nsq_q + NsqW'(pu);
			endcase
		end
		// start of the root search
		if (state_q == BK_MUL && cnt_q == ST_DONE) begin
			degtri_q <= (nsq_q == '0);
			a_q      <= '0;
			c_q      <= AccW'(nsq_q) << CShft;
			q_q      <= '0;
			bit_q    <= 5'(ROOT_W - 1);
		end
		if (state_q == BK_ITER) begin
			if (take) begin
				r_q <= diff[AccW-1:0];
				q_q <= q_q | (ROOT_W'(1) << bit_q);
			end
			a_q   <= a_add >> 1;
			c_q   <= c_q >> 2;
			bit_q <= bit_q - 5'd1;
		end
		if (fin_go && last_q) begin
			out_w_q   <= wsum_nx;
			out_deg_q <= deg_nx;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_w_q;
	assign m_tuser  = out_deg_q;

`ifndef SYNTHESIS
	a_iter_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_ITER && bit_q == 5'd0) |=> (state_q == BK_FIN))
		else $error("root search did not end in finish");
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == BK_FIN && last_q))
		else $error("result raised outside finish of last item");
	a_no_mul_in_iter: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_ITER) |-> !pv_s1)
		else $error("product pending during root search");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/cotangent_edge_weight_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Cotangent edge weight core.
// Input stream (s_*): one transaction per opposite vertex of a mesh edge; tdata holds
// end_a_x/y/z, end_b_x/y/z, opposite_x/y/z, tlast marks the edge's final opposite vertex.
// Output stream (m_*): one transaction per edge, sent on the tlast item; tdata is the
// Q16.16 weight (sum of half cotangents, saturated), tuser the degenerate flag.
// A front stage forms the edge vectors and writes them to a two-entry queue; the back
// end runs a 21-step shared-multiplier sequence (dot, cross, split squares) followed by
// a 32-step restoring root/quotient search, one bit per cycle.
// In the back end an item passes through the pop, the multiply sequence, the root search
// and the finish; the back end pops a new item only when idle, after the last one's finish.
// A zero-area triangle skips the search.
// Reset clears the running sum, the degenerate flag, the queue and the output valid flag.
// While the receiver stalls the result holds in the output register; the back end keeps
// working and waits only when another edge result is ready, the queue then fills and
// s_tready drops.
module cotangent_edge_weight_core #(
	parameter int COORD_WIDTH      = cew_pkg::COORD_WIDTH_DEF,
	parameter int WEIGHT_FRAC_BITS = cew_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z, opposite_x, opposite_y,
	// opposite_z, zero fill
	input  wire logic [((9*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,
	input  wire logic                                  s_tlast,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// edge_weight
	output logic [cew_pkg::WEIGHT_W-1:0]               m_tdata,
	// degenerate
	output logic                                       m_tuser
);
	import cew_pkg::*;

	localparam int TdW  = ((9 * COORD_WIDTH + 7) / 8) * 8;
	localparam int EntW = 6 * (COORD_WIDTH + 1) + 1;

	logic            push_valid, push_ready, pop_valid, pop_ready;
	logic [EntW-1:0] push_data, pop_data;

	cew_front #(.CoordW(COORD_WIDTH), .TdW(TdW), .EntW(EntW)) u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
		.push_valid, .push_ready, .push_data
	);

	cew_queue #(.EntW(EntW)) u_queue (
		.clk, .arst_n, .push_valid, .push_ready, .push_data,
		.pop_valid, .pop_ready, .pop_data
	);

	cew_back #(.CoordW(COORD_WIDTH), .FracW(WEIGHT_FRAC_BITS), .EntW(EntW)) u_back (
		.clk, .arst_n, .pop_valid, .pop_ready, .pop_data,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser
	);

endmodule
`default_nettype wire
